// ===== rtl/b2r565_pkg.sv =====
// Shared types and constants for the BMP 24-bit to RGB565 stream converter.
package b2r565_pkg;

  typedef enum logic [1:0] {
    KIND_WINDOW = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_END    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_MAX_WIDTH  = 2'd0,
    CFG_MAX_HEIGHT = 2'd1,
    CFG_BOTTOM_ROW = 2'd2
  } cfg_idx_e;

  localparam logic [5:0]  HDR_LEN     = 6'd54;
  localparam logic [5:0]  HDR_LAST    = 6'd53;
  localparam logic [5:0]  OFS_WIDTH0  = 6'd18;
  localparam logic [5:0]  OFS_WIDTH1  = 6'd19;
  localparam logic [5:0]  OFS_HEIGHT0 = 6'd22;
  localparam logic [5:0]  OFS_HEIGHT1 = 6'd23;
  localparam logic [5:0]  OFS_BPP     = 6'd28;
  localparam logic [5:0]  OFS_SIZE0   = 6'h22;
  localparam logic [5:0]  OFS_SIZE1   = 6'h23;
  localparam logic [5:0]  OFS_SIZE2   = 6'h24;
  localparam logic [5:0]  OFS_SIZE3   = 6'h25;
  localparam logic [7:0]  WANTED_BPP  = 8'd24;
  localparam logic [31:0] MIN_PIXEL_BYTES = 32'd3;

  localparam logic [15:0] RST_MAX_WIDTH  = 16'd240;
  localparam logic [15:0] RST_MAX_HEIGHT = 16'd320;
  localparam logic [15:0] RST_BOTTOM_ROW = 16'd319;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] color;
    logic [15:0] img_width;
    logic [15:0] img_height;
    logic [15:0] top_row;
    logic        header_error;
    logic        image_done;
  } result_t;

endpackage

// ===== rtl/bmp24_to_rgb565_stream_core.sv =====
// Top level: BMP byte stream parser and 24-bit to RGB565 pixel converter.
module bmp24_to_rgb565_stream_core
  import b2r565_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  file_byte_i,
  input  logic        first_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] color_o,
  output logic [15:0] img_width_o,
  output logic [15:0] img_height_o,
  output logic [15:0] top_row_o,
  output logic        header_error_o,
  output logic        image_done_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  // One file byte is taken per cycle. Parser state (header counter, data
  // byte count, row and pixel counters) updates in the cycle a byte is
  // accepted, and any window, pixel or end-of-image item lands in a single
  // output register in the cycle after acceptance. Sustained rate is one byte per clock;
  // the input stalls only while that output register holds an item and the
  // downstream side stalls it. Window items carry a header error flag; with
  // an error, data bytes are dropped until the next first_byte_i.

  logic [15:0] max_width_q, max_height_q, bottom_row_q;

  logic [5:0]  header_index_q, header_index_d;
  logic [31:0] data_left_q, data_left_d;
  logic [15:0] width_seen_q, width_seen_d;
  logic [15:0] height_seen_q, height_seen_d;
  logic [7:0]  depth_seen_q, depth_seen_d;
  logic        error_flag_q, error_flag_d;
  logic        active_q, active_d;
  logic [15:0] pixels_in_row_q, pixels_in_row_d;
  logic [1:0]  pad_left_q, pad_left_d;
  logic [1:0]  byte_in_pixel_q, byte_in_pixel_d;
  logic [7:0]  held_blue_q, held_blue_d;
  logic [7:0]  held_green_q, held_green_d;

  logic        out_valid_q;
  result_t     out_q;
  result_t     res;
  logic        res_valid;

  logic        in_accept;
  logic        out_load;

  logic [5:0]  idx_v;
  logic        active_v;
  logic [1:0]  pad_v;
  logic [1:0]  bip_v;
  logic [15:0] pix_v;
  logic [31:0] dl_dec;
  logic        err_v;
  logic [15:0] pix_inc;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    header_index_d  = header_index_q;
    data_left_d     = data_left_q;
    width_seen_d    = width_seen_q;
    height_seen_d   = height_seen_q;
    depth_seen_d    = depth_seen_q;
    error_flag_d    = error_flag_q;
    active_d        = active_q;
    pixels_in_row_d = pixels_in_row_q;
    pad_left_d      = pad_left_q;
    byte_in_pixel_d = byte_in_pixel_q;
    held_blue_d     = held_blue_q;
    held_green_d    = held_green_q;
    res             = '0;
    res_valid       = 1'b0;
    err_v           = 1'b0;
    pix_inc         = pixels_in_row_q + 16'd1;

    // A first byte restarts parsing at header byte 0
    idx_v    = first_byte_i ? '0 : header_index_q;
    active_v = first_byte_i ? 1'b0 : active_q;
    pad_v    = first_byte_i ? '0 : pad_left_q;
    bip_v    = first_byte_i ? '0 : byte_in_pixel_q;
    pix_v    = first_byte_i ? '0 : pixels_in_row_q;
    dl_dec   = data_left_q - 32'd1;

    if (first_byte_i) begin
      active_d        = 1'b0;
      pad_left_d      = '0;
      byte_in_pixel_d = '0;
      pixels_in_row_d = '0;
    end

    if (idx_v < HDR_LEN) begin
      case (idx_v)
        OFS_WIDTH0:  width_seen_d[7:0]   = file_byte_i;
        OFS_WIDTH1:  width_seen_d[15:8]  = file_byte_i;
        OFS_HEIGHT0: height_seen_d[7:0]  = file_byte_i;
        OFS_HEIGHT1: height_seen_d[15:8] = file_byte_i;
        OFS_BPP:     depth_seen_d        = file_byte_i;
        OFS_SIZE0:   data_left_d[7:0]    = file_byte_i;
        OFS_SIZE1:   data_left_d[15:8]   = file_byte_i;
        OFS_SIZE2:   data_left_d[23:16]  = file_byte_i;
        OFS_SIZE3:   data_left_d[31:24]  = file_byte_i;
        default: ;
      endcase
      header_index_d = idx_v + 6'd1;
      if (idx_v == HDR_LAST) begin
        err_v = (depth_seen_q != WANTED_BPP) || (width_seen_q > max_width_q) ||
                (height_seen_q > max_height_q);
        error_flag_d     = err_v;
        active_d         = !err_v && (data_left_q >= MIN_PIXEL_BYTES);
        pixels_in_row_d  = '0;
        pad_left_d       = '0;
        byte_in_pixel_d  = '0;
        res_valid        = 1'b1;
        res.kind         = KIND_WINDOW;
        res.img_width    = width_seen_q;
        res.img_height   = height_seen_q;
        res.top_row      = bottom_row_q - height_seen_q + 16'd1;
        res.header_error = err_v;
        res.image_done   = !err_v && (data_left_q < MIN_PIXEL_BYTES);
      end
    end else if (active_v) begin
      data_left_d = dl_dec;
      if (pad_v != 2'd0) begin
        pad_left_d = pad_v - 2'd1;
        if (pad_v == 2'd1 && dl_dec < MIN_PIXEL_BYTES) begin
          active_d       = 1'b0;
          res_valid      = 1'b1;
          res.kind       = KIND_END;
          res.image_done = 1'b1;
        end
      end else begin
        case (bip_v)
          2'd0: begin
            held_blue_d     = file_byte_i;
            byte_in_pixel_d = 2'd1;
          end
          2'd1: begin
            held_green_d    = file_byte_i;
            byte_in_pixel_d = 2'd2;
          end
          default: begin
            pix_inc         = pix_v + 16'd1;
            byte_in_pixel_d = '0;
            pixels_in_row_d = pix_inc;
            res_valid       = 1'b1;
            res.kind        = KIND_PIXEL;
            res.color       = {file_byte_i[7:3], held_green_q[7:2], held_blue_q[7:3]};
            res.image_done  = dl_dec < MIN_PIXEL_BYTES;
            if (dl_dec < MIN_PIXEL_BYTES) begin
              active_d = 1'b0;
            end else if (pix_inc == width_seen_q) begin
              pixels_in_row_d = '0;
              pad_left_d      = width_seen_q[1:0];
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_width_q  <= RST_MAX_WIDTH;
      max_height_q <= RST_MAX_HEIGHT;
      bottom_row_q <= RST_BOTTOM_ROW;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAX_WIDTH:  max_width_q  <= cfg_wdata_i;
        CFG_MAX_HEIGHT: max_height_q <= cfg_wdata_i;
        CFG_BOTTOM_ROW: bottom_row_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_index_q  <= '0;
      data_left_q     <= '0;
      width_seen_q    <= '0;
      height_seen_q   <= '0;
      depth_seen_q    <= '0;
      error_flag_q    <= 1'b0;
      active_q        <= 1'b0;
      pixels_in_row_q <= '0;
      pad_left_q      <= '0;
      byte_in_pixel_q <= '0;
      held_blue_q     <= '0;
      held_green_q    <= '0;
    end else if (in_accept) begin
      header_index_q  <= header_index_d;
      data_left_q     <= data_left_d;
      width_seen_q    <= width_seen_d;
      height_seen_q   <= height_seen_d;
      depth_seen_q    <= depth_seen_d;
      error_flag_q    <= error_flag_d;
      active_q        <= active_d;
      pixels_in_row_q <= pixels_in_row_d;
      pad_left_q      <= pad_left_d;
      byte_in_pixel_q <= byte_in_pixel_d;
      held_blue_q     <= held_blue_d;
      held_green_q    <= held_green_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_accept && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_accept && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign color_o        = out_q.color;
  assign img_width_o    = out_q.img_width;
  assign img_height_o   = out_q.img_height;
  assign top_row_o      = out_q.top_row;
  assign header_error_o = out_q.header_error;
  assign image_done_o   = out_q.image_done;

`ifndef SYNTH
  // header counter saturates at the end of the header
  a_hdr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    header_index_q <= HDR_LEN)
    else $error("header index past end of header");

  // pixel data is only consumed after a clean header
  a_active_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (header_index_q == HDR_LEN) && !error_flag_q)
    else $error("active without a completed, error-free header");

  // padding is only skipped on a pixel boundary
  a_pad_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pad_left_q != 2'd0) |-> (byte_in_pixel_q == 2'd0))
    else $error("padding pending mid-pixel");

  a_bip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_in_pixel_q != 2'd3)
    else $error("byte position in pixel out of range");

  // a held output item is not overwritten while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(out_q))
    else $error("stalled output item changed");
`endif

endmodule
